/* hw/rtl/swf_pkg.sv */
package swf_pkg;

   // Post-shift applied to a 128-bit magnitude product
   typedef enum logic [2:0] {
      SH_0,
      SH_16,
      SH_32,
      SH_40,
      SH_41,
      SH_FRAC
   } shift_sel_type;

   typedef struct packed {
      logic                start;
      logic signed [63:0]  a;
      logic signed [63:0]  b;
      shift_sel_type       shift;
   } mul_req_type;

   typedef struct packed {
      logic                done;
      logic                saturated;
      logic signed [63:0]  result;
   } mul_rsp_type;

   localparam int DIV_BITS = 56;
   localparam int DIVISOR_BITS = 32;

   typedef struct packed {
      logic                      start;
      logic [DIV_BITS-1:0]       dividend;
      logic [DIVISOR_BITS-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      CSR_ENERGY,
      CSR_STEP,
      CSR_NONPARABOLIC,
      CSR_KINETIC
   } csr_index_type;

   localparam logic [19:0]        MASS_MAX  = 20'hFFFFF;
   localparam logic signed [63:0] PSI_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] PSI_MIN   = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] ONE_Q16   = 64'sd65536;
   localparam logic signed [63:0] F_CLAMP   = 64'sd1099511627776;
   localparam logic signed [63:0] F_CLAMP_N = -64'sd1099511627776;

endpackage

/* hw/rtl/swf_mul.sv */
module swf_mul #(
   parameter int PSI_FRAC_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  swf_pkg::mul_req_type req,
   output swf_pkg::mul_rsp_type rsp
);
   import swf_pkg::*;

   localparam logic [2:0] LAST_PART = 3'd4;

   logic [63:0]   a_mag_ff;
   logic [63:0]   b_mag_ff;
   logic          neg_ff;
   shift_sel_type shift_ff;
   logic [127:0]  prod_ff;
   logic [2:0]    step_ff;
   logic          busy_ff;
   mul_rsp_type   rsp_ff;

   logic [31:0]   a_half;
   logic [31:0]   b_half;
   logic [63:0]   part;
   logic [127:0]  addend;
   logic [127:0]  shifted;
   logic [63:0]   limit;
   logic          sat;
   logic [63:0]   mag;

   // one 32x32 partial product per cycle: a0b0, a0b1, a1b0, a1b1
   always_comb begin
      a_half = step_ff[1] ? a_mag_ff[63:32] : a_mag_ff[31:0];
      b_half = step_ff[0] ? b_mag_ff[63:32] : b_mag_ff[31:0];
      part   = a_half * b_half;
      unique case (step_ff[1:0])
         2'd0:    addend = {64'b0, part};
         2'd3:    addend = {part, 64'b0};
         default: addend = {32'b0, part, 32'b0};
      endcase
      case (shift_ff)
         SH_16:   shifted = prod_ff >> 16;
         SH_32:   shifted = prod_ff >> 32;
         SH_40:   shifted = prod_ff >> 40;
         SH_41:   shifted = prod_ff >> 41;
         SH_FRAC: shifted = prod_ff >> PSI_FRAC_BITS;
         default: shifted = prod_ff;
      endcase
      limit = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      sat   = (|shifted[127:64]) || (shifted[63:0] > limit);
      mag   = sat ? limit : shifted[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         rsp_ff  <= '0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (req.start) begin
            a_mag_ff <= req.a[63] ? 64'(-req.a) : 64'(req.a);
            b_mag_ff <= req.b[63] ? 64'(-req.b) : 64'(req.b);
            neg_ff   <= req.a[63] ^ req.b[63];
            shift_ff <= req.shift;
            prod_ff  <= '0;
            step_ff  <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            if (step_ff == LAST_PART) begin
               busy_ff          <= 1'b0;
               rsp_ff.done      <= 1'b1;
               rsp_ff.saturated <= sat;
               rsp_ff.result    <= $signed(neg_ff ? 64'(-mag) : mag);
            end else begin
               prod_ff <= prod_ff + addend;
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

   assign rsp = rsp_ff;

endmodule

/* hw/rtl/swf_div.sv */
module swf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  swf_pkg::div_req_type req,
   output swf_pkg::div_rsp_type rsp
);
   import swf_pkg::*;

   localparam int CNT_W = $clog2(DIV_BITS);

   logic [DIV_BITS-1:0]     dvd_ff;
   logic [DIVISOR_BITS-1:0] div_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] rem_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    busy_ff;
   div_rsp_type             rsp_ff;

   logic [DIVISOR_BITS:0]   trial;
   logic [DIVISOR_BITS:0]   diff;
   logic                    ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, dvd_ff[DIV_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rsp_ff  <= '0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (req.start) begin
            dvd_ff  <= req.dividend;
            div_ff  <= req.divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[DIV_BITS-2:0], ge};
            rem_ff <= rem_in;
            if (cnt_ff == CNT_W'(DIV_BITS - 1)) begin
               busy_ff         <= 1'b0;
               rsp_ff.done     <= 1'b1;
               rsp_ff.quotient <= {dvd_ff[DIV_BITS-2:0], ge};
            end else begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   assign rsp = rsp_ff;

endmodule

/* hw/rtl/shooting_wavefunction_step.sv */
// Shooting-method wavefunction stepper: one grid sample in, one psi result out.
// One item at a time: a new sample is taken only after the previous result is posted,
// and posting waits while an earlier held result waits on rsp_tready. The work per
// item is set by the shared multiplier, built on one 32x32 array (1 to 9 products
// per item), and the bit-serial divider (0 to 2 uses). Reset (synchronous, active
// high) clears the recurrence, norm, flags and CSRs, but sets the kinetic CSR to on.
module shooting_wavefunction_step #(
   parameter int PSI_FRAC_BITS = 31
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // [31:0] potential, [51:32] band_mass, [83:52] band_gap
   input  logic [0:0]   req_tuser,   // [0] first_sample
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] psi, [126:64] norm_sum
   output logic [1:0]   rsp_tuser,   // [0] overflow, [1] divide_fault
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import swf_pkg::*;

   localparam logic signed [63:0] PSI_ONE = 64'sd1 <<< PSI_FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,      // d*d
      ST_ALPHA,   // d*d*2^16 / Eg
      ST_T,       // alpha*|E-V| / 2^32
      ST_MF,      // m0*f / 2^16
      ST_RECUR,
      ST_KS,      // mass sum (single mass in plain form) times step coefficient
      ST_K,       // times (V-E)
      ST_R,       // Sp/Sm ratio
      ST_A1,
      ST_A2,
      ST_A3,
      ST_NORM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               sat;
      logic signed [63:0] value;
   } sat_type;

   function automatic sat_type sat_add(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
      logic [64:0] s;
      sat_type     r;
      s       = {a[63], a} + {b[63], b};
      r.sat   = s[64] ^ s[63];
      r.value = r.sat ? (s[64] ? PSI_MIN : PSI_MAX) : $signed(s[63:0]);
      return r;
   endfunction

   function automatic sat_type sat_sub(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
      logic [64:0] s;
      sat_type     r;
      s       = {a[63], a} - {b[63], b};
      r.sat   = s[64] ^ s[63];
      r.value = r.sat ? (s[64] ? PSI_MIN : PSI_MAX) : $signed(s[63:0]);
      return r;
   endfunction

   state_type          state_ff;
   logic               issued_ff;

   // configuration
   logic signed [31:0] energy_ff;
   logic [39:0]        step_ff;
   logic               nonpara_ff;
   logic               kinetic_ff;

   // current item
   logic signed [31:0] v_ff;
   logic [19:0]        m0_ff;
   logic [31:0]        eg_ff;
   logic [19:0]        m_ff;

   // recurrence state
   logic signed [63:0] psi_older_ff;
   logic signed [63:0] psi_newer_ff;
   logic [19:0]        mass_older_ff;
   logic [19:0]        mass_newer_ff;
   logic signed [31:0] pot_prior_ff;
   logic [62:0]        norm_ff;
   logic [1:0]         pidx_ff;
   logic               ovf_ff;
   logic               dvf_ff;

   // working registers
   logic signed [63:0] acc_ff;
   logic signed [63:0] tmp_ff;
   logic signed [63:0] r_ff;

   // result register
   logic               rsp_valid_ff;
   logic [127:0]       rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   mul_req_type        mul_req;
   mul_rsp_type        mul_rsp;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               restart;
   logic               eg_zero_in;
   logic signed [32:0] dv_e;
   logic [32:0]        dv_e_mag;
   logic signed [32:0] dv_p;
   logic signed [63:0] d_val;
   logic [20:0]        sp;
   logic [20:0]        sm;
   logic signed [63:0] f_raw;
   logic signed [63:0] f_clamped;
   sat_type            pre_add;
   sat_type            pre_sub;
   sat_type            acc_add;
   sat_type            acc_sub;
   logic [63:0]        norm_sum;

   swf_mul #(.PSI_FRAC_BITS(PSI_FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   swf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      restart    = req_tuser[0] || (pidx_ff == 2'd0);
      eg_zero_in = req_tdata[83:52] == 32'd0;

      dv_e     = {energy_ff[31], energy_ff} - {v_ff[31], v_ff};
      dv_e_mag = dv_e[32] ? 33'(-dv_e) : 33'(dv_e);
      dv_p     = {pot_prior_ff[31], pot_prior_ff} - {energy_ff[31], energy_ff};
      d_val    = ONE_Q16 - $signed({44'b0, m0_ff});
      sp       = {1'b0, mass_newer_ff} + {1'b0, m_ff};
      sm       = {1'b0, mass_newer_ff} + {1'b0, mass_older_ff};

      // non-parabolic factor f = 1 +/- t, clamped
      f_raw = dv_e[32] ? (ONE_Q16 - mul_rsp.result) : (ONE_Q16 + mul_rsp.result);
      if (f_raw > F_CLAMP) begin
         f_clamped = F_CLAMP;
      end else if (f_raw < F_CLAMP_N) begin
         f_clamped = F_CLAMP_N;
      end else begin
         f_clamped = f_raw;
      end

      pre_add  = sat_add(psi_newer_ff, psi_newer_ff);
      pre_sub  = sat_sub(pre_add.value, psi_older_ff);
      acc_add  = sat_add(acc_ff, mul_rsp.result);
      acc_sub  = sat_sub(acc_ff, mul_rsp.result);
      norm_sum = {1'b0, norm_ff} + {1'b0, mul_rsp.result[62:0]};

      // operands for the shared multiplier
      mul_req       = '0;
      mul_req.shift = SH_0;
      unique case (state_ff)
         ST_SQ: begin
            mul_req.a = d_val;
            mul_req.b = d_val;
         end
         ST_T: begin
            mul_req.a     = tmp_ff;
            mul_req.b     = $signed({31'b0, dv_e_mag});
            mul_req.shift = SH_32;
         end
         ST_MF: begin
            mul_req.a     = $signed({44'b0, m0_ff});
            mul_req.b     = tmp_ff;
            mul_req.shift = SH_16;
         end
         ST_KS: begin
            mul_req.a = kinetic_ff ? $signed({43'b0, sp}) : $signed({44'b0, mass_newer_ff});
            mul_req.b = $signed({24'b0, step_ff});
         end
         ST_K: begin
            mul_req.a     = tmp_ff;
            mul_req.b     = $signed({{31{dv_p[32]}}, dv_p});
            mul_req.shift = kinetic_ff ? SH_41 : SH_40;
         end
         ST_A1: begin
            mul_req.a     = tmp_ff;
            mul_req.b     = psi_newer_ff;
            mul_req.shift = SH_32;
         end
         ST_A2: begin
            mul_req.a     = r_ff;
            mul_req.b     = psi_newer_ff;
            mul_req.shift = SH_32;
         end
         ST_A3: begin
            mul_req.a     = r_ff;
            mul_req.b     = psi_older_ff;
            mul_req.shift = SH_32;
         end
         ST_NORM: begin
            mul_req.a     = acc_ff;
            mul_req.b     = acc_ff;
            mul_req.shift = SH_FRAC;
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
      mul_req.start = !issued_ff &&
         (state_ff == ST_SQ || state_ff == ST_T || state_ff == ST_MF ||
          state_ff == ST_KS || state_ff == ST_K || state_ff == ST_A1 ||
          state_ff == ST_A2 || state_ff == ST_A3 || state_ff == ST_NORM);

      // operands for the divider
      div_req = '0;
      if (state_ff == ST_ALPHA) begin
         div_req.dividend = {tmp_ff[39:0], 16'b0};
         div_req.divisor  = eg_ff;
         div_req.start    = !issued_ff;
      end else if (state_ff == ST_R) begin
         div_req.dividend = {3'b0, sp, 32'b0};
         div_req.divisor  = {11'b0, sm};
         div_req.start    = !issued_ff && (sm != 21'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issued_ff     <= 1'b0;
         energy_ff     <= '0;
         step_ff       <= '0;
         nonpara_ff    <= 1'b0;
         kinetic_ff    <= 1'b1;
         psi_older_ff  <= '0;
         psi_newer_ff  <= '0;
         mass_older_ff <= '0;
         mass_newer_ff <= '0;
         pot_prior_ff  <= '0;
         norm_ff       <= '0;
         pidx_ff       <= '0;
         ovf_ff        <= 1'b0;
         dvf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // CSR writes must arrive only while idle; the block itself does not enforce this
         if (csr_psel && csr_penable && csr_pwrite) begin
            unique case (csr_index_type'(csr_paddr[4:3]))
               CSR_ENERGY:       energy_ff  <= csr_pwdata[31:0];
               CSR_STEP:         step_ff    <= csr_pwdata[39:0];
               CSR_NONPARABOLIC: nonpara_ff <= csr_pwdata[0];
               CSR_KINETIC:      kinetic_ff <= csr_pwdata[0];
            endcase
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (mul_req.start || div_req.start) begin
            issued_ff <= 1'b1;
         end else if (mul_rsp.done || div_rsp.done) begin
            issued_ff <= 1'b0;
         end

         // any saturated product is sticky overflow
         if (mul_rsp.done && mul_rsp.saturated) begin
            ovf_ff <= 1'b1;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  v_ff  <= req_tdata[31:0];
                  m0_ff <= req_tdata[51:32];
                  eg_ff <= req_tdata[83:52];
                  m_ff  <= req_tdata[51:32];
                  if (restart) begin
                     pidx_ff <= '0;
                     norm_ff <= '0;
                     ovf_ff  <= 1'b0;
                  end
                  dvf_ff   <= (dvf_ff && !restart) || (nonpara_ff && eg_zero_in);
                  state_ff <= (nonpara_ff && !eg_zero_in) ? ST_SQ : ST_RECUR;
               end
            end
            ST_SQ: begin
               if (mul_rsp.done) begin
                  tmp_ff   <= mul_rsp.result;
                  state_ff <= ST_ALPHA;
               end
            end
            ST_ALPHA: begin
               if (div_rsp.done) begin
                  tmp_ff   <= $signed({8'b0, div_rsp.quotient});
                  state_ff <= ST_T;
               end
            end
            ST_T: begin
               if (mul_rsp.done) begin
                  if (f_clamped <= 64'sd0) begin
                     // mass collapses to zero; negative f on real mass overflows
                     m_ff <= '0;
                     if (f_clamped != 64'sd0 && m0_ff != 20'd0) begin
                        ovf_ff <= 1'b1;
                     end
                     state_ff <= ST_RECUR;
                  end else begin
                     tmp_ff   <= f_clamped;
                     state_ff <= ST_MF;
                  end
               end
            end
            ST_MF: begin
               if (mul_rsp.done) begin
                  if ($unsigned(mul_rsp.result) > {44'b0, MASS_MAX}) begin
                     m_ff   <= MASS_MAX;
                     ovf_ff <= 1'b1;
                  end else begin
                     m_ff <= mul_rsp.result[19:0];
                  end
                  state_ff <= ST_RECUR;
               end
            end
            ST_RECUR: begin
               unique case (pidx_ff)
                  2'd0: begin
                     acc_ff   <= '0;
                     state_ff <= ST_NORM;
                  end
                  2'd1: begin
                     acc_ff   <= PSI_ONE;
                     state_ff <= ST_NORM;
                  end
                  default: begin
                     if (kinetic_ff) begin
                        acc_ff <= psi_newer_ff;
                        if (sp == 21'd0 || sm == 21'd0) begin
                           dvf_ff <= 1'b1;
                        end
                     end else begin
                        // plain form: 2*p1 - p0 first
                        acc_ff <= pre_sub.value;
                        if (pre_add.sat || pre_sub.sat) begin
                           ovf_ff <= 1'b1;
                        end
                     end
                     state_ff <= ST_KS;
                  end
               endcase
            end
            ST_KS: begin
               if (mul_rsp.done) begin
                  tmp_ff   <= mul_rsp.result;
                  state_ff <= ST_K;
               end
            end
            ST_K: begin
               if (mul_rsp.done) begin
                  tmp_ff   <= mul_rsp.result;
                  state_ff <= kinetic_ff ? ST_R : ST_A1;
               end
            end
            ST_R: begin
               if (sm == 21'd0) begin
                  r_ff     <= '0;
                  state_ff <= ST_A1;
               end else if (div_rsp.done) begin
                  r_ff     <= $signed({8'b0, div_rsp.quotient});
                  state_ff <= ST_A1;
               end
            end
            ST_A1: begin
               if (mul_rsp.done) begin
                  acc_ff <= acc_add.value;
                  if (acc_add.sat) begin
                     ovf_ff <= 1'b1;
                  end
                  state_ff <= kinetic_ff ? ST_A2 : ST_NORM;
               end
            end
            ST_A2: begin
               if (mul_rsp.done) begin
                  acc_ff <= acc_add.value;
                  if (acc_add.sat) begin
                     ovf_ff <= 1'b1;
                  end
                  state_ff <= ST_A3;
               end
            end
            ST_A3: begin
               if (mul_rsp.done) begin
                  acc_ff <= acc_sub.value;
                  if (acc_sub.sat) begin
                     ovf_ff <= 1'b1;
                  end
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               if (mul_rsp.done) begin
                  if (norm_sum[63]) begin
                     norm_ff <= '1;
                     ovf_ff  <= 1'b1;
                  end else begin
                     norm_ff <= norm_sum[62:0];
                  end
                  psi_older_ff  <= psi_newer_ff;
                  psi_newer_ff  <= acc_ff;
                  mass_older_ff <= mass_newer_ff;
                  mass_newer_ff <= m_ff;
                  pot_prior_ff  <= v_ff;
                  pidx_ff       <= (pidx_ff == 2'd0) ? 2'd1 : 2'd2;
                  state_ff      <= ST_OUT;
               end
            end
            ST_OUT: begin
               // wait for the result register to free up
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0, norm_ff, psi_newer_ff};
                  rsp_user_ff  <= {dvf_ff, ovf_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(csr_paddr[4:3]))
         CSR_ENERGY:       csr_prdata = {{32{energy_ff[31]}}, energy_ff};
         CSR_STEP:         csr_prdata = {24'b0, step_ff};
         CSR_NONPARABOLIC: csr_prdata = {63'b0, nonpara_ff};
         CSR_KINETIC:      csr_prdata = {63'b0, kinetic_ff};
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* hw/rtl/swf_checker.sv */
module swf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         csr_pready
);

   // one item at a time: no new item right after one is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed or dropped");

   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a result is posted as the sequencer returns to idle
   a_rsp_rise_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result posted while still busy");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready low");

endmodule

bind shooting_wavefunction_step swf_checker u_swf_checker (.*);

/* test/shooting_wavefunction_step_test.sv */
`timescale 1ns / 1ps

module shooting_wavefunction_step_test;
   import swf_pkg::*;

   localparam int PSI_FRAC = 31;
   localparam logic [63:0] NORM_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

   // One grid sample going into the stepper.
   typedef struct packed {
      logic               first_sample;
      logic signed [31:0] potential;
      logic [19:0]        band_mass;
      logic [31:0]        band_gap;
   } sample_type;

   // One wavefunction point coming out.
   typedef struct packed {
      logic signed [63:0] psi;
      logic [62:0]        norm_sum;
      logic               overflow;
      logic               divide_fault;
   } point_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [87:0]  req_tdata;   // [31:0] potential, [51:32] band_mass, [83:52] band_gap
   logic [0:0]   req_tuser;   // [0] first_sample
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // [63:0] psi, [126:64] norm_sum
   logic [1:0]   rsp_tuser;   // [0] overflow, [1] divide_fault
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [63:0]  csr_pwdata;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   shooting_wavefunction_step #(.PSI_FRAC_BITS(PSI_FRAC)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------
   // Shadow copy of the stepper: registers and recurrence state
   // ---------------------------------------------------------------
   logic signed [31:0] trial_energy;
   logic [39:0]        step_coef;
   logic               nonpar_on;
   logic               symmetric_on;

   logic signed [63:0] psi_back2, psi_back1;
   logic [19:0]        mass_back2, mass_back1;
   logic signed [31:0] v_back1;
   logic [62:0]        norm_acc;
   logic [1:0]         grid_pos;
   logic               sat_flag, div_flag;

   sample_type pending_samples[$];
   point_type  expected_points[$];

   int sender_idle_pct;
   int receiver_idle_pct;
   int mismatch_count;
   int points_checked;
   int restarts_sent;
   int sat_seen, div_seen;

   // Signed product shifted right with truncation toward zero, saturated to 64 bits.
   function automatic logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                         logic signed [63:0] b, int sh);
      logic          neg;
      logic [127:0]  ua, ub, prod, q;
      logic [63:0]   cap;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ua = {64'd0, ua[63:0]};
      ub = (b < 0) ? 128'(-b) : 128'(b);
      ub = {64'd0, ub[63:0]};
      prod = ua * ub;
      q = prod >> sh;
      cap = neg ? 64'h8000_0000_0000_0000 : NORM_CAP;
      if (q[127:64] != 0 || q[63:0] > cap) begin
         sat_flag = 1'b1;
         q = {64'd0, cap};
      end
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(MAX64)) begin sat_flag = 1'b1; return MAX64; end
      if (s < 65'(MIN64)) begin sat_flag = 1'b1; return MIN64; end
      return s[63:0];
   endfunction

   function automatic logic [19:0] mass_at_energy(logic [19:0] m0, logic [31:0] eg,
                                                  logic signed [31:0] v);
      logic signed [63:0] d, f, dv;
      logic [63:0]  sq, alpha, mag, t;
      logic [127:0] prod;
      if (!nonpar_on) return m0;
      if (eg == 0) begin
         div_flag = 1'b1;
         return m0;
      end
      d = 64'sd65536 - $signed({44'd0, m0});
      sq = d * d;
      alpha = (sq << 16) / {32'd0, eg};
      dv = 64'(trial_energy) - 64'(v);
      mag = (dv < 0) ? -dv : dv;
      t = (alpha >> 32) * mag + (((alpha & 64'hFFFF_FFFF) * mag) >> 32);
      f = (dv < 0) ? 64'sd65536 - $signed(t) : 64'sd65536 + $signed(t);
      if (f > F_CLAMP) f = F_CLAMP;
      if (f < F_CLAMP_N) f = F_CLAMP_N;
      if (f <= 0) begin
         if (f < 0 && m0 != 0) sat_flag = 1'b1;
         return '0;
      end
      prod = ({108'd0, m0} * {64'd0, f}) >> 16;
      if (prod > 128'(MASS_MAX)) begin
         sat_flag = 1'b1;
         return MASS_MAX;
      end
      return prod[19:0];
   endfunction

   // Advance the shadow recurrence by one sample and queue the point it yields.
   function automatic void predict_point(sample_type s);
      logic [19:0]        m;
      logic signed [63:0] psi, dv, kk, acc, rr, rp0, sq;
      logic [20:0]        sp, sm;
      logic [63:0]        norm_room;
      point_type          p;
      if (s.first_sample || grid_pos == 0) begin
         grid_pos = 0;
         norm_acc = '0;
         sat_flag = 1'b0;
         div_flag = 1'b0;
      end
      m = mass_at_energy(s.band_mass, s.band_gap, s.potential);
      if (grid_pos == 0) begin
         psi = 0;
         psi_back1 = 0;
         grid_pos = 1;
      end else if (grid_pos == 1) begin
         psi = 64'sd1 <<< PSI_FRAC;
         grid_pos = 2;
      end else begin
         dv = 64'(v_back1) - 64'(trial_energy);
         if (symmetric_on) begin
            sp = 21'(mass_back1) + 21'(m);
            sm = 21'(mass_back1) + 21'(mass_back2);
            if (sp == 0 || sm == 0) div_flag = 1'b1;
            kk = scaled_product($signed(64'(sp) * 64'(step_coef)), dv, 41);
            rr = (sm != 0) ? $signed((64'(sp) << 32) / 64'(sm)) : 64'sd0;
            acc = clamp_add(psi_back1, scaled_product(kk, psi_back1, 32));
            acc = clamp_add(acc, scaled_product(rr, psi_back1, 32));
            rp0 = scaled_product(rr, psi_back2, 32);
            // negating MIN64 would wrap; subtract that one term exactly
            if (rp0 == MIN64) begin
               if (acc >= 0) begin
                  sat_flag = 1'b1;
                  acc = MAX64;
               end else begin
                  acc = acc + MAX64 + 64'sd1;
               end
            end else begin
               acc = clamp_add(acc, -rp0);
            end
         end else begin
            kk = scaled_product($signed(64'(mass_back1) * 64'(step_coef)), dv, 40);
            acc = clamp_add(psi_back1, psi_back1);
            if (psi_back2 == MIN64) begin
               if (acc >= 0) begin
                  sat_flag = 1'b1;
                  acc = MAX64;
               end else begin
                  acc = acc + MAX64 + 64'sd1;
               end
            end else begin
               acc = clamp_add(acc, -psi_back2);
            end
            acc = clamp_add(acc, scaled_product(kk, psi_back1, 32));
         end
         psi = acc;
      end
      psi_back2 = psi_back1;
      psi_back1 = psi;
      mass_back2 = mass_back1;
      mass_back1 = m;
      v_back1 = s.potential;
      sq = scaled_product(psi, psi, PSI_FRAC);
      norm_room = NORM_CAP - 64'(norm_acc);
      if (64'(sq) > norm_room) begin
         sat_flag = 1'b1;
         norm_acc = NORM_CAP[62:0];
      end else begin
         norm_acc = norm_acc + sq[62:0];
      end
      p.psi = psi;
      p.norm_sum = norm_acc;
      p.overflow = sat_flag;
      p.divide_fault = div_flag;
      expected_points.push_back(p);
   endfunction

   // ---------------------------------------------------------------
   // Clock and limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Timeout for the whole run; far more than enough for the worst-case items plus stalls.
   initial begin
      #(12 * 1500000);
      $display("timeout waiting for stepper");
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------
   // Driver: feeds pending_samples into the request channel
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         // current item taken (or none up); maybe offer the next one
         if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            sample_type s;
            s = pending_samples.pop_front();
            predict_point(s);
            req_tvalid <= 1'b1;
            req_tdata <= {4'd0, s.band_gap, s.band_mass, s.potential};
            req_tuser <= s.first_sample;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random backpressure and field-by-field compare
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            point_type want;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected point psi=%h", $time, rsp_tdata[63:0]);
               mismatch_count++;
            end else begin
               want = expected_points.pop_front();
               points_checked++;
               if (want.overflow) sat_seen++;
               if (want.divide_fault) div_seen++;
               if (rsp_tdata[63:0] !== want.psi) begin
                  $display("%0t: psi expected %h actual %h", $time, want.psi, rsp_tdata[63:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[126:64] !== want.norm_sum) begin
                  $display("%0t: norm_sum expected %h actual %h", $time, want.norm_sum,
                           rsp_tdata[126:64]);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== want.overflow) begin
                  $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                           rsp_tuser[0]);
                  mismatch_count++;
               end
               if (rsp_tuser[1] !== want.divide_fault) begin
                  $display("%0t: divide_fault expected %b actual %b", $time,
                           want.divide_fault, rsp_tuser[1]);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic write_csr(csr_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx) << 3;   // step register is 40 bits, so 8-byte spacing
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_ENERGY:       trial_energy = value[31:0];
         CSR_STEP:         step_coef = value[39:0];
         CSR_NONPARABOLIC: nonpar_on = value[0];
         CSR_KINETIC:      symmetric_on = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic signed [31:0] e, logic [39:0] s, logic np, logic kf);
      write_csr(CSR_ENERGY, {{32{e[31]}}, e});
      write_csr(CSR_STEP, {24'd0, s});
      write_csr(CSR_NONPARABOLIC, {63'd0, np});
      write_csr(CSR_KINETIC, {63'd0, kf});
   endtask

   // Blocks until the stepper has drained every queued sample.
   task automatic drain;
      while (pending_samples.size() != 0 || expected_points.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic push_sample(logic first, logic signed [31:0] v, logic [19:0] m,
                              logic [31:0] eg);
      sample_type s;
      s.first_sample = first;
      s.potential = v;
      s.band_mass = m;
      s.band_gap = eg;
      if (first) restarts_sent++;
      pending_samples.push_back(s);
   endtask

   // A well-formed shot: restart then a realistic well profile; sometimes noisy.
   task automatic random_shot(int points);
      int   i;
      logic wild;
      wild = ($urandom_range(9) == 0);
      for (i = 0; i < points; i++) begin
         if (wild)
            push_sample(i == 0 ? 1'b1 : ($urandom_range(15) == 0), $urandom,
                        20'($urandom), ($urandom_range(7) == 0) ? 32'd0 : $urandom);
         else
            push_sample(i == 0, $signed($urandom_range(0, 400 << 16)) - (100 << 16),
                        20'($urandom_range(2000, 40000)),
                        $urandom_range(65536, 32'h0600_0000));
      end
   endtask

   task automatic random_config;
      case ($urandom_range(3))
         0: set_config(32'sh7FFF_FFFF, 40'hFF_FFFF_FFFF, 1'($urandom), 1'($urandom));
         1: set_config(32'sh8000_0000, 40'd0, 1'($urandom), 1'($urandom));
         default: set_config($urandom_range(0, 200 << 16),
                             40'({$urandom_range(255), $urandom}),
                             1'($urandom), 1'($urandom));
      endcase
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int phase, n;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sender_idle_pct = 6;
      receiver_idle_pct = 45;
      mismatch_count = 0;
      points_checked = 0;
      restarts_sent = 0;
      sat_seen = 0;
      div_seen = 0;
      trial_energy = '0;
      step_coef = '0;
      nonpar_on = 1'b0;
      symmetric_on = 1'b1;
      psi_back2 = '0;
      psi_back1 = '0;
      mass_back2 = '0;
      mass_back1 = '0;
      v_back1 = '0;
      norm_acc = '0;
      grid_pos = '0;
      sat_flag = 1'b0;
      div_flag = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset defaults, first point without restart flag.
      push_sample(1'b0, 32'sd0, 20'h10000, 32'd0);
      push_sample(1'b0, 32'sd0, 20'h10000, 32'd0);
      push_sample(1'b0, 32'sd0, 20'h00000, 32'd0);  // zero mass, so the last sample has a zero mass sum
      push_sample(1'b0, 32'sd0, 20'h00000, 32'd0);
      drain();

      // Symmetric, huge step and extreme potentials: psi and norm saturate.
      set_config(32'sh8000_0000, 40'hFF_FFFF_FFFF, 1'b0, 1'b1);
      push_sample(1'b1, 32'sh7FFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);
      push_sample(1'b0, 32'sh7FFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);
      push_sample(1'b0, 32'sh8000_0000, 20'hFFFFF, 32'hFFFF_FFFF);
      push_sample(1'b0, 32'sh7FFF_FFFF, 20'h00001, 32'h0000_0001);
      push_sample(1'b0, 32'sh8000_0000, 20'hFFFFF, 32'd0);
      drain();

      // Plain form, non-parabolic: zero gap, negative mass, mass saturation; then symmetric.
      set_config(32'sh7FFF_FFFF, 40'h00_1000_0000, 1'b1, 1'b0);
      push_sample(1'b1, 32'sd0, 20'h08000, 32'd0);
      push_sample(1'b0, 32'sh8000_0000, 20'h30000, 32'h0000_0001);
      push_sample(1'b0, 32'sh7FFF_FFFF, 20'h30000, 32'h0001_0000);
      push_sample(1'b0, 32'sd0, 20'hFFFFF, 32'h0000_0001);
      push_sample(1'b1, 32'sd100, 20'h01000, 32'h0010_0000);
      push_sample(1'b0, 32'sd200, 20'h01000, 32'h0010_0000);
      push_sample(1'b0, 32'sd300, 20'h00000, 32'h0010_0000);
      drain();
      set_config(32'sd0, 40'd0, 1'b1, 1'b1);
      set_config(-32'sd5000000, 40'h00_0800_0000, 1'b1, 1'b1);
      push_sample(1'b1, 32'sd0, 20'h00000, 32'h0000_0000);
      push_sample(1'b0, 32'sh7FFF_FFFF, 20'h10000, 32'hFFFF_FFFF);
      push_sample(1'b0, 32'sd0, 20'h1A000, 32'h0100_0000);
      push_sample(1'b0, 32'sd0, 20'h1A000, 32'h0100_0000);
      drain();

      // Random: three backpressure profiles, ~950 items across many shots.
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 45 : 0;
         receiver_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 6 : 0;
         n = 0;
         while (n < 310) begin
            int pts;
            if ($urandom_range(3) == 0) begin
               drain();
               random_config();
            end
            pts = $urandom_range(3, 30);
            random_shot(pts);
            n += pts;
         end
         drain();
      end

      $display("checked %0d points over %0d restarts, %0d with overflow, %0d with divide fault",
               points_checked, restarts_sent, sat_seen, div_seen);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d points never seen", mismatch_count,
                  expected_points.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* shooting_wavefunction_step.f */
hw/rtl/swf_pkg.sv
hw/rtl/swf_mul.sv
hw/rtl/swf_div.sv
hw/rtl/shooting_wavefunction_step.sv
hw/rtl/swf_checker.sv
test/shooting_wavefunction_step_test.sv
